// ===== design/sidasc_pkg.sv =====
package sidasc_pkg;

   localparam int unsigned NUM_DIGITS = 10;
   localparam int unsigned POS_WIDTH  = 4;

   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_MINUS = 8'd45;
   localparam logic [3:0] RADIX       = 4'd10;

   localparam logic [POS_WIDTH-1:0] TOP_POS = POS_WIDTH'(NUM_DIGITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   typedef struct packed {
      logic load;
      logic emit_sign;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic neg;
      logic pos_zero;
      logic slot_free;
   } status_type;

   // Weight of one decimal position.
   function automatic logic [31:0] pow10(input logic [POS_WIDTH-1:0] k);
      logic [31:0] p;
      begin
         case (k)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
         endcase
         return p;
      end
   endfunction

endpackage

// ===== design/sidasc_ctrl.sv =====
module sidasc_ctrl
   import sidasc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (!status.neg) begin
               state_in = ST_DIGIT;
            end else if (status.slot_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (status.slot_free) begin
               cmd.step = 1'b1;
               if (status.pos_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Units digit done means the request is finished.
   assert property (@(posedge clock) disable iff (reset)
      cmd.step && status.pos_zero |=> state_ff == ST_IDLE)
      else $error("controller did not return to idle after units digit");

   // Never write the output register while it still holds an untaken character.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.step) |-> status.slot_free)
      else $error("output written while occupied");

endmodule

// ===== design/sidasc_dp.sv =====
module sidasc_dp
   import sidasc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] req_value,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);

   logic [31:0]          mag_ff, mag_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic                 neg_ff, neg_in;
   logic                 started_ff, started_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           char_ff, char_in;
   logic                 last_ff, last_in;

   logic [31:0] weight;
   logic [3:0]  digit;
   logic [31:0] multiple;
   logic        emit_digit;
   logic        slot_free;

   assign weight    = pow10(pos_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Largest d in 1..9 with d * weight <= mag; compares are independent.
   always_comb begin
      logic [33:0] prod;
      digit    = 4'd0;
      multiple = '0;
      for (int d = 1; d <= 9; d++) begin
         prod = {2'b00, weight} * 34'(d);
         if ({2'b00, mag_ff} >= prod) begin
            digit    = 4'(d);
            multiple = prod[31:0];
         end
      end
   end

   assign emit_digit = started_ff || (digit != 4'd0) || (pos_ff == '0);

   always_comb begin
      mag_in     = mag_ff;
      pos_in     = pos_ff;
      neg_in     = neg_ff;
      started_in = started_ff;
      if (cmd.load) begin
         neg_in     = req_value[31];
         mag_in     = req_value[31] ? (32'd0 - req_value) : req_value;
         pos_in     = TOP_POS;
         started_in = 1'b0;
      end else if (cmd.step) begin
         mag_in = mag_ff - multiple;
         pos_in = pos_ff - POS_WIDTH'(1);
         if (emit_digit) begin
            started_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (cmd.emit_sign) begin
         rsp_valid_in = 1'b1;
         char_in      = ASCII_MINUS;
         last_in      = 1'b0;
      end else if (cmd.step && emit_digit) begin
         rsp_valid_in = 1'b1;
         char_in      = ASCII_ZERO + {4'b0000, digit};
         last_in      = (pos_ff == '0);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      pos_ff     <= pos_in;
      neg_ff     <= neg_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign status.neg       = neg_ff;
   assign status.pos_zero  = (pos_ff == '0);
   assign status.slot_free = slot_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   // Remainder must fit below the next higher position's weight.
   assert property (@(posedge clock) disable iff (reset)
      cmd.step && (pos_ff != TOP_POS) |->
         ({2'b00, mag_ff} < ({2'b00, weight} * 34'(RADIX))))
      else $error("remainder exceeds current decimal position");

   // Every character sent is a minus sign or a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (char_ff == ASCII_MINUS) ||
         ((char_ff >= ASCII_ZERO) && (char_ff <= (ASCII_ZERO + 8'd9))))
      else $error("illegal output character");

endmodule

// ===== design/signed_int_to_decimal_ascii_top.sv =====
// A request is handled as one load step, a sign step that sends a minus sign only for
// a negative value, then ten decimal positions resolved one per cycle, most significant
// first, while the output register is free; a full output stalls these steps. Leading-zero
// positions still take a step but produce no character, so the first digit comes later for
// fewer digits. A new request is taken only after the units digit is written to the output.
// Reset (synchronous, active high) returns the controller to idle and empties the output.
module signed_int_to_decimal_ascii_top
   import sidasc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);

   cmd_type    cmd;
   status_type status;

   sidasc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sidasc_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import sidasc_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int RANDOM_COUNT = 62;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } ascii_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_character;
   logic        rsp_last;

   logic [31:0]    pending_values[$];
   ascii_char_type expected_chars[$];
   int             sender_idle_pct = 0;
   int             receiver_stall_pct = 0;
   int             error_count = 0;
   int             quiet_cycles = 0;

   signed_int_to_decimal_ascii_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Append the decimal text of one value, sign first, most significant digit first.
   function automatic void queue_decimal_text(input logic [31:0] value);
      logic [31:0]    magnitude;
      logic [3:0]     digits[10];
      int             digit_count;
      ascii_char_type ch;
      begin
         magnitude   = value[31] ? 32'(-value) : value;
         digit_count = 0;
         do begin
            digits[digit_count] = 4'(magnitude % RADIX);
            magnitude           = magnitude / RADIX;
            digit_count++;
         end while (magnitude != 0 && digit_count < 10);
         if (value[31]) begin
            ch.character = ASCII_MINUS;
            ch.last      = 1'b0;
            expected_chars.push_back(ch);
         end
         for (int k = digit_count - 1; k >= 0; k--) begin
            ch.character = ASCII_ZERO + 8'(digits[k]);
            ch.last      = (k == 0);
            expected_chars.push_back(ch);
         end
      end
   endfunction

   // Driver: hold the request until it is taken, then load the next one or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
      end else begin
         if (req_valid && req_ready)
            queue_decimal_text(req_value);
         if (!req_valid || req_ready) begin
            if (pending_values.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_value <= pending_values.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted character with the oldest expected one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character %0d last %0b", $time,
                        rsp_character, rsp_last);
               error_count++;
            end else begin
               ascii_char_type exp_char;
               exp_char = expected_chars.pop_front();
               if (rsp_character !== exp_char.character) begin
                  $display("%0t: character expected %0d actual %0d", $time,
                           exp_char.character, rsp_character);
                  error_count++;
               end
               if (rsp_last !== exp_char.last) begin
                  $display("%0t: last expected %0b actual %0b", $time,
                           exp_char.last, rsp_last);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Mostly values of a chosen digit count so every length shows up often.
   task automatic queue_random_values(input int count);
      longint lo;
      longint hi;
      longint magnitude;
      int     num_digits;
      int     kind;
      begin
         for (int i = 0; i < count; i++) begin
            kind = $urandom_range(9);
            if (kind < 2) begin
               pending_values.push_back($urandom);
            end else if (kind == 2) begin
               pending_values.push_back(32'($signed($urandom_range(40)) - 20));
            end else begin
               num_digits = $urandom_range(1, 10);
               lo = 1;
               repeat (num_digits - 1) lo = lo * 10;
               hi = (num_digits == 10) ? 64'd2147483647 : lo * 10 - 1;
               if (num_digits == 1)
                  lo = 0;
               magnitude = lo + longint'($urandom) % (hi - lo + 1);
               if ($urandom_range(1))
                  magnitude = -magnitude;
               pending_values.push_back(32'(magnitude));
            end
         end
      end
   endtask

   task automatic wait_until_drained();
      begin
         while (pending_values.size() != 0 || req_valid || expected_chars.size() != 0)
            @(posedge clock);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      pending_values.push_back(32'd0);
      pending_values.push_back(32'd1);
      pending_values.push_back(-32'sd1);
      pending_values.push_back(32'd9);
      pending_values.push_back(32'd10);
      pending_values.push_back(-32'sd10);
      pending_values.push_back(32'd99);
      pending_values.push_back(32'd100);
      pending_values.push_back(32'h7FFF_FFFF);
      pending_values.push_back(32'h8000_0000);
      pending_values.push_back(32'h8000_0001);
      pending_values.push_back(32'd1000000000);
      pending_values.push_back(32'd999999999);
      pending_values.push_back(-32'sd1000000000);
      pending_values.push_back(32'd1234567890);
      pending_values.push_back(-32'sd1234567890);
      pending_values.push_back(32'h5555_5555);
      pending_values.push_back(32'hAAAA_AAAA);
      pending_values.push_back(-32'sd9);
      pending_values.push_back(32'd1999999999);
      pending_values.push_back(32'd2147483640);
      wait_until_drained();

      queue_random_values(RANDOM_COUNT);
      wait_until_drained();

      sender_idle_pct = 73;
      queue_random_values(RANDOM_COUNT);
      wait_until_drained();

      sender_idle_pct    = 0;
      receiver_stall_pct = 73;
      queue_random_values(RANDOM_COUNT);
      wait_until_drained();

      sender_idle_pct    = 24;
      receiver_stall_pct = 24;
      queue_random_values(RANDOM_COUNT);
      wait_until_drained();

      // Let any stray character surface before the verdict.
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
